FILE: rtl/core/abs_pkg.sv
// Shared types and constants for the alternating bit sender.
`timescale 1ns / 1ps

package abs_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int SUM_W         = 13;
    localparam int TIMER_W       = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;
    localparam int ADDR_W        = 3;

    localparam logic [IDX_W-1:0]   LAST_IDX      = IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(10);

    // Register indexes on the configuration port.
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        CMD_MSG  = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // One packet transmission request: sequence bit and packet checksum.
    typedef struct packed {
        logic             seq;
        logic [SUM_W-1:0] ck;
    } t_send_req;

    // Write port into the message buffer.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } t_buf_wr;

endpackage

FILE: rtl/core/abs_front.sv
// Front end: accepts items, tracks protocol state and the timer, queues sends.
`timescale 1ns / 1ps

module abs_front import abs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic signed [7:0]  i_data_byte,
    input  logic signed [1:0]  i_rx_seqnum,
    input  logic signed [1:0]  i_rx_acknum,
    input  logic signed [31:0] i_rx_checksum,
    input  logic [TIMER_W-1:0] i_timeout,
    input  logic               i_back_busy,
    input  logic               i_q_full,
    output logic               o_q_push,
    output t_send_req          o_q_data,
    output t_buf_wr            o_buf_wr
);

    logic               r_awaiting, n_awaiting;
    logic               r_seq, n_seq;
    logic [IDX_W-1:0]   r_msg_idx, n_msg_idx;
    logic [SUM_W-1:0]   r_send_sum, n_send_sum;
    logic [IDX_W-1:0]   r_ack_idx, n_ack_idx;
    logic [SUM_W-1:0]   r_ack_sum, n_ack_sum;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_running, n_running;

    logic               accept;
    logic [SUM_W-1:0]   byte_ext;
    logic [SUM_W-1:0]   msg_sum;
    logic [SUM_W-1:0]   ack_sum_new;
    logic [SUM_W+1:0]   ack_total;
    logic               ack_ok;
    logic [TIMER_W-1:0] timer_start;
    t_cmd               cmd;

    assign cmd = t_cmd'(i_command);

    // A message byte that will be stored must wait until the back end has
    // finished reading the buffer; every item needs room in the send queue.
    assign o_in_ready = !i_q_full && !(cmd == CMD_MSG && r_awaiting && i_back_busy);
    assign accept     = i_in_valid && o_in_ready;

    assign byte_ext    = {{(SUM_W-8){i_data_byte[7]}}, i_data_byte};
    assign msg_sum     = r_send_sum + byte_ext;
    assign ack_sum_new = r_ack_sum + byte_ext;
    assign ack_total   = {{2{ack_sum_new[SUM_W-1]}}, ack_sum_new}
                       + {{SUM_W{i_rx_seqnum[1]}}, i_rx_seqnum}
                       + {{SUM_W{i_rx_acknum[1]}}, i_rx_acknum};
    assign ack_ok      = ({{(32-SUM_W-2){ack_total[SUM_W+1]}}, ack_total} == i_rx_checksum)
                      && (i_rx_acknum == {1'b0, r_seq});
    assign timer_start = (i_timeout == '0) ? TIMER_W'(1) : i_timeout;

    always_comb begin
        n_awaiting  = r_awaiting;
        n_seq       = r_seq;
        n_msg_idx   = r_msg_idx;
        n_send_sum  = r_send_sum;
        n_ack_idx   = r_ack_idx;
        n_ack_sum   = r_ack_sum;
        n_timer     = r_timer;
        n_running   = r_running;
        o_q_push    = 1'b0;
        o_q_data.seq = r_seq;
        o_q_data.ck  = r_send_sum + {{(SUM_W-2){1'b0}}, r_seq, 1'b0};
        o_buf_wr.en   = 1'b0;
        o_buf_wr.idx  = r_msg_idx;
        o_buf_wr.data = i_data_byte;
        if (accept) begin
            case (cmd)
                CMD_MSG: begin
                    if (r_awaiting) begin
                        o_buf_wr.en = 1'b1;
                        n_send_sum  = msg_sum;
                        if (r_msg_idx == LAST_IDX) begin
                            n_msg_idx  = '0;
                            n_ack_idx  = '0;
                            n_ack_sum  = '0;
                            n_awaiting = 1'b0;
                            n_timer    = timer_start;
                            n_running  = 1'b1;
                            o_q_push   = 1'b1;
                            o_q_data.ck = msg_sum + {{(SUM_W-2){1'b0}}, r_seq, 1'b0};
                        end else begin
                            n_msg_idx = r_msg_idx + IDX_W'(1);
                        end
                    end
                end
                CMD_ACK: begin
                    if (!r_awaiting) begin
                        if (r_ack_idx == LAST_IDX) begin
                            n_ack_idx = '0;
                            n_ack_sum = '0;
                            if (ack_ok) begin
                                n_running  = 1'b0;
                                n_timer    = '0;
                                n_seq      = !r_seq;
                                n_awaiting = 1'b1;
                                n_send_sum = '0;
                                n_msg_idx  = '0;
                            end
                        end else begin
                            n_ack_idx = r_ack_idx + IDX_W'(1);
                            n_ack_sum = ack_sum_new;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_running) begin
                        if (r_timer > TIMER_W'(1)) begin
                            n_timer = r_timer - TIMER_W'(1);
                        end else begin
                            n_timer  = timer_start;
                            o_q_push = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b1;
            r_seq      <= 1'b0;
            r_msg_idx  <= '0;
            r_send_sum <= '0;
            r_ack_idx  <= '0;
            r_ack_sum  <= '0;
            r_timer    <= '0;
            r_running  <= 1'b0;
        end else begin
            r_awaiting <= n_awaiting;
            r_seq      <= n_seq;
            r_msg_idx  <= n_msg_idx;
            r_send_sum <= n_send_sum;
            r_ack_idx  <= n_ack_idx;
            r_ack_sum  <= n_ack_sum;
            r_timer    <= n_timer;
            r_running  <= n_running;
        end
    end

endmodule

FILE: rtl/core/abs_queue.sv
// Short queue of send requests between the front end and the back end.
`timescale 1ns / 1ps

module abs_queue import abs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_send_req i_data,
    input  logic      i_pop,
    output t_send_req o_data,
    output logic      o_empty,
    output logic      o_full
);

    t_send_req         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/abs_back.sv
// Back end: holds the message buffer and plays packets out byte by byte.
`timescale 1ns / 1ps

module abs_back import abs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_buf_wr               i_buf_wr,
    input  logic                  i_q_empty,
    input  t_send_req             i_q_data,
    output logic                  o_q_pop,
    output logic                  o_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_out_seqnum,
    output logic                  o_out_acknum,
    output logic signed [SUM_W-1:0] o_out_checksum,
    output logic signed [7:0]     o_out_byte,
    output logic                  o_last
);

    logic [7:0]       r_buf [PAYLOAD_BYTES];
    logic             r_active;
    logic [IDX_W-1:0] r_idx;
    t_send_req        r_req;
    logic             r_out_valid;
    logic             r_out_seq;
    logic [SUM_W-1:0] r_out_ck;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             slot_free;
    logic             emit;

    assign slot_free = !r_out_valid || i_out_ready;
    assign emit      = r_active && slot_free;
    assign o_q_pop   = !r_active && !i_q_empty;
    assign o_busy    = r_active;

    assign o_out_valid    = r_out_valid;
    assign o_out_seqnum   = r_out_seq;
    assign o_out_acknum   = r_out_seq;
    assign o_out_checksum = r_out_ck;
    assign o_out_byte     = r_out_byte;
    assign o_last         = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_buf_wr.en) begin
            r_buf[i_buf_wr.idx] <= i_buf_wr.data;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req <= i_q_data;
        end
        if (emit) begin
            r_out_seq  <= r_req.seq;
            r_out_ck   <= r_req.ck;
            r_out_byte <= r_buf[r_idx];
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (emit) begin
                if (r_idx == LAST_IDX) begin
                    r_active <= 1'b0;
                    r_idx    <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/alternating_bit_sender_core.sv
// Top level of the alternating bit protocol sender with its register port.
// Path: a finishing item queues a send request; the back end pops it and its output register
// then presents the first byte. Throughput: one input item per cycle while o_in_ready is high;
// a packet leaves the queue and then plays out PAYLOAD_BYTES (20) bytes; message bytes stall meanwhile.
// Reset: synchronous active-low i_rst_n; idle, sequence bit 0, timer stopped, timeout 10.
`timescale 1ns / 1ps

module alternating_bit_sender_core import abs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input item channel.
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_command,
    input  logic signed [7:0]       i_data_byte,
    input  logic signed [1:0]       i_rx_seqnum,
    input  logic signed [1:0]       i_rx_acknum,
    input  logic signed [31:0]      i_rx_checksum,
    // Result item channel, one item per packet byte.
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_out_seqnum,
    output logic                    o_out_acknum,
    output logic signed [SUM_W-1:0] o_out_checksum,
    output logic signed [7:0]       o_out_byte,
    output logic                    o_last,
    // Register port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // The timeout register sits at byte address 0; bit 2 of the address
    // selects the register slot and the low two bits address bytes in it.
    logic [TIMER_W-1:0] r_timeout;
    logic               reg_sel;
    logic               reg_wr;

    t_buf_wr   buf_wr;
    t_send_req q_in;
    t_send_req q_out;
    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    logic      q_full;
    logic      back_active;
    logic      back_busy;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1];
    assign reg_wr  = psel && penable && pwrite && (reg_sel == REG_TIMEOUT);
    assign prdata  = (reg_sel == REG_TIMEOUT) ? {{(32-TIMER_W){1'b0}}, r_timeout} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (reg_wr) begin
            r_timeout <= pwdata[TIMER_W-1:0];
        end
    end

    // The buffer is still being read while a packet is queued or playing out,
    // so new message bytes are held off until the back end has drained.
    assign back_busy = back_active || !q_empty;

    // The front end classifies each item: message bytes fill the buffer and the
    // send checksum, ack bytes build the ack checksum, ticks run the timer.
    // A completed message or a timer expiry queues one send request.
    abs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .i_rx_seqnum   (i_rx_seqnum),
        .i_rx_acknum   (i_rx_acknum),
        .i_rx_checksum (i_rx_checksum),
        .i_timeout     (r_timeout),
        .i_back_busy   (back_busy),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in),
        .o_buf_wr      (buf_wr)
    );

    // Send requests carry their own sequence bit and checksum, so the front end
    // may move on (for example take a matching ack) while a resend waits.
    abs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back end replays the buffer through a registered output stage, so a
    // stalled downstream holds the playout first and reaches the front end once the send
    // queue is full, or at once for message bytes that wait on the busy back end.
    abs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_buf_wr       (buf_wr),
        .i_q_empty      (q_empty),
        .i_q_data       (q_out),
        .o_q_pop        (q_pop),
        .o_busy         (back_active),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_seqnum   (o_out_seqnum),
        .o_out_acknum   (o_out_acknum),
        .o_out_checksum (o_out_checksum),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

endmodule
